/* rtl/core/lfs_pkg.sv */
// ----------------------------------------------------------------------------
// lfs_pkg
// shared types, constants and helpers for the led frame store streamer
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int unsigned LED_COUNT_DEF  = 48;
  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned COLOR_W        = 3 * CHAN_W;
  localparam int unsigned IDX_FIELD_W    = 8;
  localparam logic [CHAN_W-1:0] BRIGHT_RST = 8'd255;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_FILL = 2'd1,
    OP_SHOW = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_SHOW
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_set;       // write the incoming colour at the incoming index
    logic wr_fill;      // write the latched colour at the sweep counter
    logic latch_color;  // capture the incoming colour for a fill
    logic cnt_clr;
    logic cnt_inc;
    logic issue;        // read one entry into the output pipeline
    logic issue_last;   // that entry ends the show
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic adv;          // output pipeline may move
    logic cnt_end;      // sweep counter at the final entry
  } status_t;

  // floor(p / 255) for any 16-bit product of two bytes
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
    logic [2*CHAN_W:0] t;
    t = {1'b0, p} + {{(CHAN_W+1){1'b0}}, p[2*CHAN_W-1:CHAN_W]} + {{(2*CHAN_W){1'b0}}, 1'b1};
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

endpackage

/* rtl/core/lfs_ram.sv */
// ----------------------------------------------------------------------------
// lfs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lfs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 48,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lfs_datapath.sv */
// ----------------------------------------------------------------------------
// lfs_datapath
// frame store, sweep counter, brightness register and scaling pipeline
// ----------------------------------------------------------------------------
module lfs_datapath #(
  parameter int unsigned LED_COUNT = lfs_pkg::LED_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfs_pkg::cmd_t                       cmd_i,
  output lfs_pkg::status_t                    status_o,
  input  logic [lfs_pkg::IDX_FIELD_W-1:0]     led_index_i,
  input  logic [lfs_pkg::COLOR_W-1:0]         color_i,      // red, green, blue from msb
  input  logic                                cfg_we_i,
  input  logic [lfs_pkg::CHAN_W-1:0]          cfg_wdata_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [lfs_pkg::COLOR_W-1:0]         m_tdata_o,
  output logic                                m_tlast_o
);
  import lfs_pkg::*;

  localparam int unsigned IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IDX_W-1:0] CNT_END = IDX_W'(LED_COUNT - 1);

  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [COLOR_W-1:0] fill_q;
  logic [CHAN_W-1:0]  bright_q;
  logic [LED_COUNT-1:0] vld_q;
  logic               adv;
  logic               set_ok;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [COLOR_W-1:0] wdata;
  logic [COLOR_W-1:0] rdata;
  logic [COLOR_W-1:0] entry;
  logic               v1_q, l1_q, vld1_q;
  logic               v2_q, l2_q;
  logic [2*CHAN_W-1:0] pr_q, pg_q, pb_q;
  logic               out_v_q, out_l_q;
  logic [COLOR_W-1:0] out_q;

  assign adv      = !out_v_q || m_tready_i;
  assign set_ok   = led_index_i < IDX_FIELD_W'(LED_COUNT);
  assign status_o = '{adv: adv, cnt_end: (cnt_q == CNT_END)};

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      bright_q <= BRIGHT_RST;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        bright_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_color) begin
      fill_q <= color_i;
    end
  end

  // store write port
  assign we    = (cmd_i.wr_set && set_ok) || cmd_i.wr_fill;
  assign waddr = cmd_i.wr_fill ? cnt_q : led_index_i[IDX_W-1:0];
  assign wdata = cmd_i.wr_fill ? fill_q : color_i;

  // entries never written since reset read as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[waddr] <= 1'b1;
    end
  end

  lfs_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (LED_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      vld1_q <= vld_q[cnt_q];
    end
  end

  assign entry = vld1_q ? rdata : '0;

  // pipeline control, all stages move together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q    <= cmd_i.issue;
      v2_q    <= v1_q;
      out_v_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1_q    <= cmd_i.issue_last;
      l2_q    <= l1_q;
      out_l_q <= l2_q;
      pr_q    <= entry[3*CHAN_W-1:2*CHAN_W] * bright_q;
      pg_q    <= entry[2*CHAN_W-1:CHAN_W]   * bright_q;
      pb_q    <= entry[CHAN_W-1:0]          * bright_q;
      out_q   <= {div255(pg_q), div255(pr_q), div255(pb_q)};
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_q;
  assign m_tlast_o  = out_l_q;

endmodule

/* rtl/core/lfs_ctrl.sv */
// ----------------------------------------------------------------------------
// lfs_ctrl
// sequencer for set, fill and show items
// ----------------------------------------------------------------------------
module lfs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [1:0]       op_i,
  input  lfs_pkg::status_t status_i,
  output lfs_pkg::cmd_t    cmd_o
);
  import lfs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          case (op_e'(op_i))
            OP_SET: begin
              cmd_o.wr_set = 1'b1;
            end
            OP_FILL: begin
              cmd_o.latch_color = 1'b1;
              cmd_o.cnt_clr     = 1'b1;
              state_d           = ST_FILL;
            end
            OP_SHOW: begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_SHOW;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.wr_fill = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (status_i.cnt_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHOW: begin
        if (status_i.adv) begin
          cmd_o.issue      = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.issue_last = status_i.cnt_end;
          if (status_i.cnt_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/led_frame_store_streamer.sv */
// ----------------------------------------------------------------------------
// led_frame_store_streamer
// led colour frame store with brightness scaling and streamed show output
// ----------------------------------------------------------------------------
// usage
//   slave channel takes one command beat: set one led, fill all leds or show
//   the frame. set gives no beat; a set whose index is at or beyond the led
//   count is dropped. fill sweeps the store, one entry a cycle, so the slave
//   side is busy until the sweep has written the final entry.
//   show streams LED_COUNT beats on the master channel in index order, each
//   channel scaled by floor(c * brightness / 255) and packed green, red,
//   blue; tlast marks the final beat. the first read passes the read,
//   multiply and divide stages before the first beat, then one beat a
//   cycle follows while the receiver keeps tready high, a pace set by the
//   single store read port. a show holds the slave side until its last
//   read is issued, so receiver stalls lengthen that hold.
//   a receiver stall freezes the whole scaling pipeline and the read issue,
//   nothing is lost. the next command is taken as soon as the last read of a
//   show is issued, while the final beats still drain.
//   reset clears the store to black (per-entry valid flags, no sweep) and
//   sets brightness to 255. the user must write brightness through cfg_we_i
//   only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module led_frame_store_streamer #(
  parameter int unsigned LED_COUNT = lfs_pkg::LED_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config: brightness
  input  logic                          cfg_we_i,
  input  logic [lfs_pkg::CHAN_W-1:0]    cfg_wdata_i,
  // command beats
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // op[1:0], led_index[9:2], red[17:10], green[25:18], blue[33:26], zero pad
  input  logic [39:0]                   s_axis_tdata,
  // pixel beats
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_word[23:0]: blue[7:0], red[15:8], green[23:16]
  output logic [lfs_pkg::COLOR_W-1:0]   m_axis_tdata,
  output logic                          m_axis_tlast
);
  import lfs_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic [1:0]         op;
  logic [IDX_FIELD_W-1:0] led_index;
  logic [COLOR_W-1:0] color;

  // unpack the command beat
  assign op        = s_axis_tdata[1:0];
  assign led_index = s_axis_tdata[9:2];
  // stored as red, green, blue from the top
  assign color     = {s_axis_tdata[17:10], s_axis_tdata[25:18], s_axis_tdata[33:26]};

  lfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .op_i       (op),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfs_datapath #(
    .LED_COUNT (LED_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .led_index_i (led_index),
    .color_i     (color),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

/* tb/sv/tb_led_frame_store_streamer.sv */
// ----------------------------------------------------------------------------
// tb_led_frame_store_streamer
// self-checking bench for the led frame store streamer
// ----------------------------------------------------------------------------
// command beats go in on the slave channel, from a short directed table first
// and then from random phases, each phase with its own brightness and its own
// mix of sender idling and receiver stalls. a shadow copy of the frame store
// and the brightness register predicts every pixel beat of a show. pixel
// beats are checked in order against the queue of predicted words.
// ----------------------------------------------------------------------------
module tb_led_frame_store_streamer;

  import lfs_pkg::*;

  localparam int unsigned LEDS        = LED_COUNT_DEF;
  localparam int          HOLD_CYCLES = 300;          // long receiver hold-off
  localparam int          SETTLE_CYC  = LEDS + 16;    // fill sweep plus pipeline
  localparam int          PHASE_ITEMS = 44;           // items per phase
  localparam int          N_PHASES    = 8;
  localparam int          N_DIR       = 15;
  localparam int          MAX_REPORTS = 10;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;         // spare op code, dropped

  // one command beat as the block sees it
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_cmd_t;

  // directed row: a command, and where obvious the word every led must show
  typedef struct packed {
    led_cmd_t    cmd;
    logic        lit;       // word typed in below rather than predicted
    logic [23:0] lit_word;
  } dir_row_t;

  // one random phase
  typedef struct packed {
    logic [6:0] tx_pct;     // sender idle chance in percent
    logic [6:0] rx_pct;     // receiver stall chance in percent
    logic       rnd_bright;
    logic [7:0] bright;
    logic       hold;       // long receiver hold-off at phase start
    logic       pause;      // sender waits for the pipe to drain mid phase
  } phase_t;

  typedef struct {
    logic [23:0] word;
    logic        is_last;
  } pixel_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // black store straight after reset
    '{'{OP_SHOW,   8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'h000000},
    '{'{OP_FILL,   8'h00, 8'hff, 8'hff, 8'hff}, 1'b0, 24'h0},
    // full white at full brightness
    '{'{OP_SHOW,   8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, 24'hffffff},
    '{'{OP_SET,    8'd0,  8'h12, 8'h34, 8'h56}, 1'b0, 24'h0},
    '{'{OP_SET,    8'd47, 8'hff, 8'h00, 8'h80}, 1'b0, 24'h0},
    // just past the end, then far past it: both dropped
    '{'{OP_SET,    8'd48, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
    '{'{OP_SET,    8'hff, 8'h01, 8'h02, 8'h03}, 1'b0, 24'h0},
    // spare op code with every field bit set
    '{'{OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, 24'h0},
    // show with junk in the ignored fields
    '{'{OP_SHOW,   8'haa, 8'h55, 8'h55, 8'h55}, 1'b0, 24'h0},
    // fill ignores its index
    '{'{OP_FILL,   8'hff, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0},
    '{'{OP_SHOW,   8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, 24'h000000},
    '{'{OP_SET,    8'd1,  8'h80, 8'h7f, 8'h01}, 1'b0, 24'h0},
    '{'{OP_SET,    8'd46, 8'haa, 8'h55, 8'hff}, 1'b0, 24'h0},
    '{'{OP_SET,    8'd0,  8'hff, 8'hff, 8'hff}, 1'b0, 24'h0},
    '{'{OP_SHOW,   8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 24'h0}
  };

  localparam phase_t PHASES [N_PHASES] = '{
    '{7'd0,  7'd0,  1'b0, 8'd255, 1'b0, 1'b0},   // flat out
    '{7'd59, 7'd0,  1'b0, 8'd0,   1'b0, 1'b0},   // dark, sender idles
    '{7'd0,  7'd59, 1'b0, 8'd1,   1'b0, 1'b0},   // dimmest, receiver stalls
    '{7'd26, 7'd26, 1'b0, 8'd128, 1'b0, 1'b0},   // both sides idle
    '{7'd0,  7'd0,  1'b0, 8'd254, 1'b1, 1'b0},   // receiver holds off, block fills
    '{7'd26, 7'd26, 1'b1, 8'd0,   1'b0, 1'b1},   // sender pauses to drain
    '{7'd0,  7'd59, 1'b1, 8'd0,   1'b0, 1'b0},
    '{7'd59, 7'd0,  1'b1, 8'd0,   1'b0, 1'b0}
  };

  // ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // op[1:0], led_index[9:2], red[17:10], green[25:18], blue[33:26], zero pad
  logic [39:0] s_axis_tdata  = 40'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pixel_word[23:0]: blue[7:0], red[15:8], green[23:16]
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  // shadow state of the block
  logic [7:0]  shadow_r [LEDS];
  logic [7:0]  shadow_g [LEDS];
  logic [7:0]  shadow_b [LEDS];
  logic [7:0]  shadow_bright;
  pixel_t      pixel_q [$];         // predicted pixel beats, oldest first

  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          mism_count   = 0;
  logic        hold_toggle  = 1'b0; // flipped by the sender to ask for a hold-off
  logic        hold_seen    = 1'b0;
  int          hold_left    = 0;

  led_frame_store_streamer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever begin
      #2 clk_i = ~clk_i;
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #(4 * 1000000);
    $display("** led_frame_store_streamer: FAILED **");
    $finish;
  end

  // floor(c * brightness / 255)
  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] b);
    int unsigned prod;
    prod = int'(c) * int'(b);
    return 8'(prod / 255);
  endfunction

  function automatic void note_bad(input string msg);
    mism_count++;
    if (mism_count <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // update the shadow store and queue the beats a show gives
  function automatic void predict_cmd(input led_cmd_t c, input logic lit,
                                      input logic [23:0] lit_word);
    pixel_t p;
    case (c.op)
      OP_SET: begin
        if (c.idx < LEDS) begin
          shadow_r[c.idx] = c.red;
          shadow_g[c.idx] = c.green;
          shadow_b[c.idx] = c.blue;
        end
      end
      OP_FILL: begin
        for (int i = 0; i < LEDS; i++) begin
          shadow_r[i] = c.red;
          shadow_g[i] = c.green;
          shadow_b[i] = c.blue;
        end
      end
      OP_SHOW: begin
        for (int i = 0; i < LEDS; i++) begin
          p.word    = lit ? lit_word : {scale_chan(shadow_g[i], shadow_bright),
                                        scale_chan(shadow_r[i], shadow_bright),
                                        scale_chan(shadow_b[i], shadow_bright)};
          p.is_last = (i == LEDS - 1);
          pixel_q.push_back(p);
        end
      end
      default: begin
        // spare op code: nothing happens
      end
    endcase
  endfunction

  // offer one command beat, idling first at the phase rate; returns at the
  // rising edge that took it
  task automatic offer_cmd(input led_cmd_t c, input logic lit, input logic [23:0] lit_word);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, c.blue, c.green, c.red, c.idx, c.op};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    predict_cmd(c, lit, lit_word);
  endtask

  // drop valid and wait for every predicted beat to come out
  task automatic drain_pixels();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // brightness is only written with the block idle: drained, and a fill
  // sweep's worth of cycles on top since set and fill give no beat
  task automatic write_brightness(input logic [7:0] v);
    drain_pixels();
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_bright = v;
  endtask

  function automatic logic [7:0] rand_chan();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      return 8'h00;
    end else if (sel < 20) begin
      return 8'hff;
    end
    return 8'($urandom_range(255));
  endfunction

  // mostly sets and shows, some fills, a few dropped beats
  function automatic led_cmd_t rand_cmd();
    led_cmd_t    c;
    int unsigned sel;
    sel     = $urandom_range(99);
    c.idx   = 8'($urandom_range(255));
    c.red   = rand_chan();
    c.green = rand_chan();
    c.blue  = rand_chan();
    if (sel < 55) begin
      c.op = OP_SET;
      if ($urandom_range(99) < 88) begin
        c.idx = 8'($urandom_range(LEDS - 1));
      end else begin
        c.idx = 8'($urandom_range(255, LEDS));
      end
    end else if (sel < 67) begin
      c.op = OP_FILL;
    end else if (sel < 92) begin
      c.op = OP_SHOW;
    end else begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // receiver side: random stalls at the phase rate, or a long hold-off
  // counted here once the sender flips hold_toggle
  always @(negedge clk_i) begin
    if (hold_seen != hold_toggle) begin
      hold_seen     <= hold_toggle;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // pixel beat checker
  always @(posedge clk_i) begin
    pixel_t p;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        note_bad($sformatf("unexpected beat word %06h last %0b",
                           m_axis_tdata, m_axis_tlast));
      end else begin
        p = pixel_q.pop_front();
        if (m_axis_tdata !== p.word) begin
          note_bad($sformatf("pixel word expected %06h got %06h", p.word, m_axis_tdata));
        end
        if (m_axis_tlast !== p.is_last) begin
          note_bad($sformatf("tlast expected %0b got %0b", p.is_last, m_axis_tlast));
        end
      end
    end
  end

  initial begin
    led_cmd_t c;
    phase_t   ph;
    int       done;
    for (int i = 0; i < LEDS; i++) begin
      shadow_r[i] = 8'd0;
      shadow_g[i] = 8'd0;
      shadow_b[i] = 8'd0;
    end
    shadow_bright = BRIGHT_RST;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, at reset brightness, no idling
    for (int r = 0; r < N_DIR; r++) begin
      offer_cmd(DIR_ROWS[r].cmd, DIR_ROWS[r].lit, DIR_ROWS[r].lit_word);
    end

    // random phases
    for (int k = 0; k < N_PHASES; k++) begin
      ph = PHASES[k];
      write_brightness(ph.rnd_bright ? 8'($urandom_range(255)) : ph.bright);
      tx_idle_pct  = ph.tx_pct;
      rx_stall_pct = ph.rx_pct;
      if (ph.hold) begin
        hold_toggle = ~hold_toggle;
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        c = rand_cmd();
        offer_cmd(c, 1'b0, 24'h0);
        done++;
        if (ph.pause && done == PHASE_ITEMS / 2) begin
          drain_pixels();
        end
      end
    end

    drain_pixels();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mism_count == 0 && pixel_q.size() == 0) begin
      $display("** led_frame_store_streamer: PASSED **");
    end else begin
      $display("** led_frame_store_streamer: FAILED **");
    end
    $finish;
  end

endmodule
